// File: rtl/core/dclrd_pkg.sv
// Package for the DEFLATE code-length run decoder.
// Holds field widths, symbol and status codes, and the result beat type.
// No dependencies.
package dclrd_pkg;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 9;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LITERAL_COUNT  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISTANCE_COUNT = 1'd1;

   localparam logic [8:0] LITERAL_COUNT_MIN  = 9'd257;
   localparam logic [8:0] LITERAL_COUNT_MAX  = 9'd288;
   localparam logic [5:0] DISTANCE_COUNT_MIN = 6'd1;
   localparam logic [5:0] DISTANCE_COUNT_MAX = 6'd32;

   // commands
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SYMBOL = 1'b1;

   // code-length alphabet
   localparam logic [4:0] SYM_REPEAT_PREVIOUS = 5'd16;
   localparam logic [4:0] SYM_ZERO_SHORT      = 5'd17;
   localparam logic [4:0] SYM_ZERO_LONG       = 5'd18;
   localparam logic [7:0] RUN_BASE_SHORT      = 8'd3;
   localparam logic [7:0] RUN_BASE_LONG       = 8'd11;
   localparam logic [9:0] END_CODE_INDEX      = 10'd256;

   // result status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_SYMBOL  = 3'd1;
   localparam logic [2:0] ST_NO_PREVIOUS = 3'd2;
   localparam logic [2:0] ST_OVERRUN     = 3'd3;
   localparam logic [2:0] ST_END_ZERO    = 3'd4;
   localparam logic [2:0] ST_ALL_ZERO    = 3'd5;

   typedef struct packed {
      logic [2:0] status;
      logic       to_distance_table;
      logic [8:0] first_entry;
      logic [7:0] run_length;
      logic [3:0] length_value;
      logic       table_complete;
      logic       last;
   } rsp_beat_type;

endpackage

// File: rtl/core/deflate_code_length_run_decoder.sv
// Top level of the DEFLATE code-length run decoder.
// Depends on dclrd_pkg for codes, widths and the result beat type.
//
// Usage:
//   req_* carries one beat per decoded code-length symbol, or a start command
//   (req_command low) that clears the table state and gives no result.
//   rsp_* carries run descriptors: one per symbol, two when a run crosses the
//   literal/distance boundary, or a single error beat. After an error every
//   symbol is dropped until the next start command.
//   csr_* writes the literal and distance code counts; values are clamped.
//   Write them only while no result is outstanding.
// Timing:
//   A symbol is decoded in the cycle it is accepted and its result beats are
//   offered from the next cycle on. One symbol per cycle is accepted while
//   each gives one beat and the receiver does not stall; a split run gives
//   two beats. The rate is set by the four-entry result queue, which takes
//   new symbols while it holds at most one beat.
//   Reset clears the table state, sets the counts to 257 and 1 and empties
//   the queue. A stalled receiver holds the head beat; once two beats wait,
//   req_stall rises.
module deflate_code_length_run_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [dclrd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dclrd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [4:0]                           req_code_symbol,
   input  logic [6:0]                           req_repeat_bits,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_status,
   output logic                                 rsp_to_distance_table,
   output logic [8:0]                           rsp_first_entry,
   output logic [7:0]                           rsp_run_length,
   output logic [3:0]                           rsp_length_value,
   output logic                                 rsp_table_complete,
   output logic                                 rsp_last
);
   import dclrd_pkg::*;

   // configuration
   logic [8:0] literal_count_ff;
   logic [5:0] distance_count_ff;
   logic [8:0] literal_count_in;
   logic [5:0] distance_count_in;

   // table state
   logic [8:0] next_position_ff, next_position_in;
   logic [3:0] previous_length_ff, previous_length_in;
   logic [8:0] literal_zero_ff, literal_zero_in;
   logic [5:0] distance_zero_ff, distance_zero_in;
   logic       failed_ff, failed_in;

   // result queue
   rsp_beat_type queue_ff [4];
   logic [1:0]   write_ptr_ff, read_ptr_ff, count_ff;
   rsp_beat_type beat0, beat1, head;
   logic [1:0]   push_count;
   logic         pop, accept, symbol_beat;

   // decode
   logic [3:0] run_len_value;
   logic [7:0] run;
   logic [9:0] pos, endp, total, lit, run_w;
   logic [9:0] lit_piece, dist_start, dist_piece;
   logic       bad_symbol, no_previous, end_zero, overrun, all_zero;
   logic       has_lit, has_dist, complete;
   logic [8:0] literal_zero_next;
   logic [5:0] distance_zero_next;
   rsp_beat_type lit_beat, dist_beat;
   logic [2:0] error_status;
   logic       is_error;

   assign accept      = req_valid && !req_stall;
   assign symbol_beat = accept && (req_command == CMD_SYMBOL) && !failed_ff;
   assign req_stall   = count_ff[1];
   assign rsp_valid   = (count_ff != 2'd0);
   assign pop         = rsp_valid && !rsp_stall;

   // clamp of configuration writes
   always_comb begin
      literal_count_in  = literal_count_ff;
      distance_count_in = distance_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LITERAL_COUNT: begin
               if (csr_write_data < LITERAL_COUNT_MIN)
                  literal_count_in = LITERAL_COUNT_MIN;
               else if (csr_write_data > LITERAL_COUNT_MAX)
                  literal_count_in = LITERAL_COUNT_MAX;
               else
                  literal_count_in = csr_write_data;
            end
            default: begin
               if (csr_write_data[5:0] < DISTANCE_COUNT_MIN)
                  distance_count_in = DISTANCE_COUNT_MIN;
               else if (csr_write_data[5:0] > DISTANCE_COUNT_MAX)
                  distance_count_in = DISTANCE_COUNT_MAX;
               else
                  distance_count_in = csr_write_data[5:0];
            end
         endcase
      end
   end

   // symbol decode
   always_comb begin
      bad_symbol    = (req_code_symbol > SYM_ZERO_LONG);
      run_len_value = 4'd0;
      if (req_code_symbol < SYM_REPEAT_PREVIOUS) begin
         run_len_value = req_code_symbol[3:0];
         run           = 8'd1;
      end else if (req_code_symbol == SYM_REPEAT_PREVIOUS) begin
         run_len_value = previous_length_ff;
         run           = RUN_BASE_SHORT + {6'd0, req_repeat_bits[1:0]};
      end else if (req_code_symbol == SYM_ZERO_SHORT) begin
         run           = RUN_BASE_SHORT + {5'd0, req_repeat_bits[2:0]};
      end else begin
         run           = RUN_BASE_LONG + {1'b0, req_repeat_bits};
      end

      pos   = {1'b0, next_position_ff};
      run_w = {2'd0, run};
      endp  = pos + run_w;
      lit   = {1'b0, literal_count_ff};
      total = lit + {4'd0, distance_count_ff};

      no_previous = (req_code_symbol == SYM_REPEAT_PREVIOUS) && (pos == 10'd0);
      end_zero    = (run_len_value == 4'd0) && (pos <= END_CODE_INDEX)
                    && (endp > END_CODE_INDEX) && (total > END_CODE_INDEX);
      overrun     = (pos >= total) || (endp > total);

      has_lit    = (pos < lit);
      has_dist   = (endp > lit);
      lit_piece  = (endp < lit) ? run_w : (lit - pos);
      dist_start = (pos > lit) ? pos : lit;
      dist_piece = endp - dist_start;
      complete   = (endp == total);

      literal_zero_next  = literal_zero_ff;
      distance_zero_next = distance_zero_ff;
      if (run_len_value == 4'd0 && has_lit)
         literal_zero_next = literal_zero_ff + lit_piece[8:0];
      if (run_len_value == 4'd0 && has_dist)
         distance_zero_next = distance_zero_ff + dist_piece[5:0];
      all_zero = (literal_zero_next == literal_count_ff)
                 || ((distance_count_ff > 6'd1)
                     && (distance_zero_next == distance_count_ff));

      // checks in priority order
      is_error     = 1'b1;
      error_status = ST_OK;
      if (bad_symbol)
         error_status = ST_BAD_SYMBOL;
      else if (no_previous)
         error_status = ST_NO_PREVIOUS;
      else if (end_zero)
         error_status = ST_END_ZERO;
      else if (overrun)
         error_status = ST_OVERRUN;
      else if (all_zero)
         error_status = ST_ALL_ZERO;
      else
         is_error = 1'b0;
   end

   // beats and state update
   always_comb begin
      lit_beat.status            = ST_OK;
      lit_beat.to_distance_table = 1'b0;
      lit_beat.first_entry       = next_position_ff;
      lit_beat.run_length        = lit_piece[7:0];
      lit_beat.length_value      = run_len_value;
      lit_beat.table_complete    = complete && !has_dist;
      lit_beat.last              = !has_dist;

      dist_beat.status            = ST_OK;
      dist_beat.to_distance_table = 1'b1;
      dist_beat.first_entry       = dist_start[8:0] - literal_count_ff;
      dist_beat.run_length        = dist_piece[7:0];
      dist_beat.length_value      = run_len_value;
      dist_beat.table_complete    = complete;
      dist_beat.last              = 1'b1;

      beat1 = dist_beat;
      if (is_error) begin
         beat0        = '0;
         beat0.status = error_status;
         beat0.last   = 1'b1;
      end else begin
         beat0 = has_lit ? lit_beat : dist_beat;
      end

      push_count = 2'd0;
      if (symbol_beat)
         push_count = (!is_error && has_lit && has_dist) ? 2'd2 : 2'd1;

      next_position_in   = next_position_ff;
      previous_length_in = previous_length_ff;
      literal_zero_in    = literal_zero_ff;
      distance_zero_in   = distance_zero_ff;
      failed_in          = failed_ff;
      if (accept && req_command == CMD_START) begin
         next_position_in   = '0;
         previous_length_in = '0;
         literal_zero_in    = '0;
         distance_zero_in   = '0;
         failed_in          = 1'b0;
      end else if (symbol_beat) begin
         if (!bad_symbol && req_code_symbol < SYM_REPEAT_PREVIOUS)
            previous_length_in = req_code_symbol[3:0];
         // the all-zero check comes after the run is counted
         if (!bad_symbol && !no_previous && !end_zero && !overrun) begin
            next_position_in = endp[8:0];
            literal_zero_in  = literal_zero_next;
            distance_zero_in = distance_zero_next;
         end
         failed_in = is_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         literal_count_ff   <= LITERAL_COUNT_MIN;
         distance_count_ff  <= DISTANCE_COUNT_MIN;
         next_position_ff   <= '0;
         previous_length_ff <= '0;
         literal_zero_ff    <= '0;
         distance_zero_ff   <= '0;
         failed_ff          <= 1'b0;
         write_ptr_ff       <= '0;
         read_ptr_ff        <= '0;
         count_ff           <= '0;
      end else begin
         literal_count_ff   <= literal_count_in;
         distance_count_ff  <= distance_count_in;
         next_position_ff   <= next_position_in;
         previous_length_ff <= previous_length_in;
         literal_zero_ff    <= literal_zero_in;
         distance_zero_ff   <= distance_zero_in;
         failed_ff          <= failed_in;
         write_ptr_ff       <= write_ptr_ff + push_count;
         read_ptr_ff        <= read_ptr_ff + {1'b0, pop};
         count_ff           <= count_ff + push_count - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0)
         queue_ff[write_ptr_ff] <= beat0;
      if (push_count == 2'd2)
         queue_ff[write_ptr_ff + 2'd1] <= beat1;
   end

   assign head                  = queue_ff[read_ptr_ff];
   assign rsp_status            = head.status;
   assign rsp_to_distance_table = head.to_distance_table;
   assign rsp_first_entry       = head.first_entry;
   assign rsp_run_length        = head.run_length;
   assign rsp_length_value      = head.length_value;
   assign rsp_table_complete    = head.table_complete;
   assign rsp_last              = head.last;

   // error beats carry nothing but the code and the last flag
   a_error_beat : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_last && rsp_run_length == 8'd0))
      else $error("error beat with payload or without last");

   a_ok_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK) |-> (rsp_run_length != 8'd0))
      else $error("empty run descriptor");

   a_complete_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_complete) |-> rsp_last)
      else $error("table complete on a non-final beat");

   a_start_clears : assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_START)
      |=> (next_position_ff == 9'd0 && !failed_ff))
      else $error("start command did not clear the table");

   a_error_sticks : assert property (@(posedge clock) disable iff (reset)
      (symbol_beat && is_error) |=> failed_ff)
      else $error("error not latched");

endmodule
